[hdl/hpt_pkg.sv]
package hpt_pkg;

   localparam int CW       = 32;            // coordinate / matrix entry width
   localparam int FRAC     = 16;            // fraction bits of Q16.16
   localparam int PW       = 2 * CW;        // full product width
   localparam int NW       = PW - FRAC + 1; // column sum width (49)
   localparam int RW       = NW + 1;        // divider partial remainder width
   localparam int QBITS    = CW;            // quotient bits, one per divider stage
   localparam int NUM_REGS = 8;
   localparam int CSR_IDX_W = 8;
   localparam int CSR_DW   = 64;

   localparam int COL_LAT  = 3;             // product, pair sums, final sum
   localparam int DIV_LAT  = QBITS + 3;     // magnitude, setup, steps, saturate
   localparam int PIPE_LAT = COL_LAT + DIV_LAT;

   localparam logic [CSR_IDX_W-1:0] REG_M11_M12 = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_M13_M14 = 8'd1;
   localparam logic [CSR_IDX_W-1:0] REG_M21_M22 = 8'd2;
   localparam logic [CSR_IDX_W-1:0] REG_M23_M24 = 8'd3;
   localparam logic [CSR_IDX_W-1:0] REG_M31_M32 = 8'd4;
   localparam logic [CSR_IDX_W-1:0] REG_M33_M34 = 8'd5;
   localparam logic [CSR_IDX_W-1:0] REG_M41_M42 = 8'd6;
   localparam logic [CSR_IDX_W-1:0] REG_M43_M44 = 8'd7;

   localparam logic [CW-1:0] SAT_POS = 32'h7FFF_FFFF;
   localparam logic [CW-1:0] SAT_NEG = 32'h8000_0000;

   typedef logic [NUM_REGS-1:0][CSR_DW-1:0] cfg_bank_type;

   // identity matrix
   localparam cfg_bank_type CFG_RESET = {
      64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000, 64'h0,
      64'h0, 64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000};

   typedef struct packed {
      logic signed [CW-1:0] in_x;
      logic signed [CW-1:0] in_y;
      logic signed [CW-1:0] in_z;
   } req_type;

   typedef struct packed {
      logic signed [CW-1:0] out_x;
      logic signed [CW-1:0] out_y;
      logic signed [CW-1:0] out_z;
      logic                 w_zero;
   } rsp_type;

   // one matrix column, rows 1..4
   typedef struct packed {
      logic signed [CW-1:0] r0;
      logic signed [CW-1:0] r1;
      logic signed [CW-1:0] r2;
      logic signed [CW-1:0] r3;
   } col_coef_type;

   typedef struct packed {
      logic neg;
      logic ovf;
   } div_ctrl_type;

   // entry of row r, column c (0..3) out of the register bank
   function automatic logic signed [CW-1:0] hpt_entry(cfg_bank_type cfg, int r, int c);
      logic [2:0]        ri;
      logic [CSR_DW-1:0] word;
      int                idx;
      idx  = r * 4 + c;
      ri   = 3'(idx >> 1);
      word = cfg[ri];
      return ((idx & 1) != 0) ? word[CW-1:0] : word[CSR_DW-1:CW];
   endfunction

   function automatic col_coef_type hpt_column_coef(cfg_bank_type cfg, int c);
      col_coef_type k;
      k.r0 = hpt_entry(cfg, 0, c);
      k.r1 = hpt_entry(cfg, 1, c);
      k.r2 = hpt_entry(cfg, 2, c);
      k.r3 = hpt_entry(cfg, 3, c);
      return k;
   endfunction

endpackage

[hdl/hpt_column.sv]
module hpt_column (
   input  logic                           clock,
   input  logic                           enable,
   input  logic signed [hpt_pkg::CW-1:0]  x,
   input  logic signed [hpt_pkg::CW-1:0]  y,
   input  logic signed [hpt_pkg::CW-1:0]  z,
   input  hpt_pkg::col_coef_type          coef,
   output logic signed [hpt_pkg::NW-1:0]  sum
);

   logic signed [hpt_pkg::PW-1:0] p0_in, p1_in, p2_in, p0_ff, p1_ff, p2_ff;
   logic signed [hpt_pkg::CW-1:0] m3_ff;
   logic signed [hpt_pkg::NW-1:0] a_in, b_in, a_ff, b_ff, sum_in, sum_ff;

   always_comb begin
      p0_in = x * coef.r0;
      p1_in = y * coef.r1;
      p2_in = z * coef.r2;
      // drop 16 fraction bits (floor), then pair up the four terms
      a_in = {p0_ff[hpt_pkg::PW-1], p0_ff[hpt_pkg::PW-1:hpt_pkg::FRAC]} +
             {p1_ff[hpt_pkg::PW-1], p1_ff[hpt_pkg::PW-1:hpt_pkg::FRAC]};
      b_in = {p2_ff[hpt_pkg::PW-1], p2_ff[hpt_pkg::PW-1:hpt_pkg::FRAC]} +
             {{(hpt_pkg::NW-hpt_pkg::CW){m3_ff[hpt_pkg::CW-1]}}, m3_ff};
      sum_in = a_ff + b_ff;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         p0_ff  <= p0_in;
         p1_ff  <= p1_in;
         p2_ff  <= p2_in;
         m3_ff  <= coef.r3;
         a_ff   <= a_in;
         b_ff   <= b_in;
         sum_ff <= sum_in;
      end
   end

   assign sum = sum_ff;

endmodule

[hdl/hpt_div_step.sv]
module hpt_div_step (
   input  logic                       clock,
   input  logic                       enable,
   input  logic [hpt_pkg::RW-1:0]     rem_in,
   input  logic [hpt_pkg::QBITS-1:0]  low_in,
   input  logic [hpt_pkg::QBITS-1:0]  q_in,
   input  logic [hpt_pkg::NW-1:0]     dm_in,
   input  hpt_pkg::div_ctrl_type      ctrl_in,
   output logic [hpt_pkg::RW-1:0]     rem_out,
   output logic [hpt_pkg::QBITS-1:0]  low_out,
   output logic [hpt_pkg::QBITS-1:0]  q_out,
   output logic [hpt_pkg::NW-1:0]     dm_out,
   output hpt_pkg::div_ctrl_type      ctrl_out
);

   logic [hpt_pkg::RW-1:0]    trial, diff, rem_in_nx, rem_ff;
   logic                      ge;
   logic [hpt_pkg::QBITS-1:0] low_ff, q_ff;
   logic [hpt_pkg::NW-1:0]    dm_ff;
   hpt_pkg::div_ctrl_type     ctrl_ff;

   // restoring step: shift in the next dividend bit, subtract if it fits
   always_comb begin
      trial     = {rem_in[hpt_pkg::RW-2:0], low_in[hpt_pkg::QBITS-1]};
      diff      = trial - {1'b0, dm_in};
      ge        = trial >= {1'b0, dm_in};
      rem_in_nx = ge ? diff : trial;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff  <= rem_in_nx;
         low_ff  <= {low_in[hpt_pkg::QBITS-2:0], 1'b0};
         q_ff    <= {q_in[hpt_pkg::QBITS-2:0], ge};
         dm_ff   <= dm_in;
         ctrl_ff <= ctrl_in;
      end
   end

   assign rem_out  = rem_ff;
   assign low_out  = low_ff;
   assign q_out    = q_ff;
   assign dm_out   = dm_ff;
   assign ctrl_out = ctrl_ff;

endmodule

[hdl/hpt_divider.sv]
module hpt_divider (
   input  logic                          clock,
   input  logic                          enable,
   input  logic signed [hpt_pkg::NW-1:0] num,
   input  logic signed [hpt_pkg::NW-1:0] den,
   output logic signed [hpt_pkg::CW-1:0] quot
);

   localparam int Q = hpt_pkg::QBITS;

   logic [hpt_pkg::NW-1:0] nm_in, dm_in, nm_ff, dm0_ff;
   logic                   neg_ff;
   hpt_pkg::div_ctrl_type  ctrl_in;

   logic [hpt_pkg::RW-1:0] rem_s  [Q+1];
   logic [Q-1:0]           low_s  [Q+1];
   logic [Q-1:0]           q_s    [Q+1];
   logic [hpt_pkg::NW-1:0] dm_s   [Q+1];
   hpt_pkg::div_ctrl_type  ctrl_s [Q+1];

   logic [hpt_pkg::RW-1:0] rem0_ff;
   logic [Q-1:0]           low0_ff;
   logic [hpt_pkg::NW-1:0] dm1_ff;
   hpt_pkg::div_ctrl_type  ctrl0_ff;

   logic                   sat;
   logic [Q-1:0]           quot_in, quot_ff;

   always_comb begin
      nm_in = num[hpt_pkg::NW-1] ? (~num + 1'b1) : num;
      dm_in = den[hpt_pkg::NW-1] ? (~den + 1'b1) : den;
      ctrl_in.neg = neg_ff;
      // quotient reaches 2^32 exactly when |n| >= |w| * 2^16
      ctrl_in.ovf = {{hpt_pkg::FRAC{1'b0}}, nm_ff} >= {dm0_ff, {hpt_pkg::FRAC{1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         nm_ff    <= nm_in;
         dm0_ff   <= dm_in;
         neg_ff   <= num[hpt_pkg::NW-1] ^ den[hpt_pkg::NW-1];
         rem0_ff  <= {{(hpt_pkg::RW-hpt_pkg::NW+hpt_pkg::FRAC){1'b0}},
                      nm_ff[hpt_pkg::NW-1:hpt_pkg::FRAC]};
         low0_ff  <= {nm_ff[hpt_pkg::FRAC-1:0], {(Q-hpt_pkg::FRAC){1'b0}}};
         dm1_ff   <= dm0_ff;
         ctrl0_ff <= ctrl_in;
      end
   end

   assign rem_s[0]  = rem0_ff;
   assign low_s[0]  = low0_ff;
   assign q_s[0]    = '0;
   assign dm_s[0]   = dm1_ff;
   assign ctrl_s[0] = ctrl0_ff;

   for (genvar k = 0; k < Q; k++) begin : g_step
      hpt_div_step u_step (
         .clock    (clock),
         .enable   (enable),
         .rem_in   (rem_s[k]),
         .low_in   (low_s[k]),
         .q_in     (q_s[k]),
         .dm_in    (dm_s[k]),
         .ctrl_in  (ctrl_s[k]),
         .rem_out  (rem_s[k+1]),
         .low_out  (low_s[k+1]),
         .q_out    (q_s[k+1]),
         .dm_out   (dm_s[k+1]),
         .ctrl_out (ctrl_s[k+1])
      );
   end

   // same threshold both ways: +2^31 and up clamps, -2^31 and below clamps
   always_comb begin
      sat = ctrl_s[Q].ovf || q_s[Q][Q-1];
      if (ctrl_s[Q].neg) begin
         quot_in = sat ? hpt_pkg::SAT_NEG : (~q_s[Q] + 1'b1);
      end else begin
         quot_in = sat ? hpt_pkg::SAT_POS : q_s[Q];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         quot_ff <= quot_in;
      end
   end

   assign quot = quot_ff;

endmodule

[hdl/homogeneous_point_transform.sv]
// Homogeneous point transform: (x, y, z, 1) times a 4x4 matrix, then divide by w.
//
// Request channel (req_valid / req_stall / req_data): one Q16.16 point per request,
// taken at a clock edge with req_valid high and req_stall low.
// Response channel (rsp_valid / rsp_stall / rsp_data): one result per request, in
// request order; out_x/y/z are the saturated Q16.16 quotients, w_zero flags a
// zero weight, in which case the coordinates read as zero.
// CSR port (csr_valid / csr_ready / csr_index / csr_wdata): eight 64-bit matrix
// registers; csr_ready is always high, indexes above 7 are dropped. Write only
// while no request is in flight.
//
// Throughput: one request per cycle while no stalled response holds the pipeline.
// The path is 39 register stages (the first loads at the accepting edge): three
// multiply/sum stages, magnitude, overflow check, the 32 one-bit restoring divider
// stages, saturation and the output register.
// When rsp_stall holds a valid response, the whole pipeline freezes and
// req_stall rises in the same cycle; an empty output register never blocks.
// Reset (synchronous) empties the pipeline and loads the identity matrix.
module homogeneous_point_transform (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  hpt_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output hpt_pkg::rsp_type                 rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [hpt_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [hpt_pkg::CSR_DW-1:0]       csr_wdata
);

   hpt_pkg::cfg_bank_type cfg_ff, cfg_in;

   logic                           adv;
   logic [hpt_pkg::PIPE_LAT-1:0]   v_ff;
   logic [hpt_pkg::DIV_LAT-1:0]    wz_ff;
   logic                           rsp_valid_ff;
   hpt_pkg::rsp_type               rsp_ff, rsp_in;

   logic signed [hpt_pkg::NW-1:0]  col_sum [4];
   logic signed [hpt_pkg::CW-1:0]  quot    [3];

   // advance everything unless a held response is being stalled
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;
   assign csr_ready = 1'b1;

   // register bank write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            hpt_pkg::REG_M11_M12: cfg_in[0] = csr_wdata;
            hpt_pkg::REG_M13_M14: cfg_in[1] = csr_wdata;
            hpt_pkg::REG_M21_M22: cfg_in[2] = csr_wdata;
            hpt_pkg::REG_M23_M24: cfg_in[3] = csr_wdata;
            hpt_pkg::REG_M31_M32: cfg_in[4] = csr_wdata;
            hpt_pkg::REG_M33_M34: cfg_in[5] = csr_wdata;
            hpt_pkg::REG_M41_M42: cfg_in[6] = csr_wdata;
            hpt_pkg::REG_M43_M44: cfg_in[7] = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= hpt_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // four column units: x, y, z numerators and the weight
   for (genvar c = 0; c < 4; c++) begin : g_col
      hpt_column u_col (
         .clock  (clock),
         .enable (adv),
         .x      (req_data.in_x),
         .y      (req_data.in_y),
         .z      (req_data.in_z),
         .coef   (hpt_pkg::hpt_column_coef(cfg_ff, c)),
         .sum    (col_sum[c])
      );
   end

   for (genvar c = 0; c < 3; c++) begin : g_div
      hpt_divider u_div (
         .clock  (clock),
         .enable (adv),
         .num    (col_sum[c]),
         .den    (col_sum[3]),
         .quot   (quot[c])
      );
   end

   // valid bits and zero-weight flag ride along with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         v_ff         <= {v_ff[hpt_pkg::PIPE_LAT-2:0], req_valid};
         rsp_valid_ff <= v_ff[hpt_pkg::PIPE_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         wz_ff  <= {wz_ff[hpt_pkg::DIV_LAT-2:0], col_sum[3] == '0};
         rsp_ff <= rsp_in;
      end
   end

   // force the zero vector when w rounded to zero
   always_comb begin
      if (wz_ff[hpt_pkg::DIV_LAT-1]) begin
         rsp_in.out_x  = '0;
         rsp_in.out_y  = '0;
         rsp_in.out_z  = '0;
         rsp_in.w_zero = 1'b1;
      end else begin
         rsp_in.out_x  = quot[0];
         rsp_in.out_y  = quot[1];
         rsp_in.out_z  = quot[2];
         rsp_in.w_zero = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_wzero_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.w_zero |->
         rsp_data.out_x == '0 && rsp_data.out_y == '0 && rsp_data.out_z == '0)
      else $error("w_zero response with nonzero coordinates");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && v_ff == '0)
      else $error("pipeline not empty after reset");

   a_freeze: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> $stable(v_ff))
      else $error("valid bits moved while pipeline frozen");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a stalled response");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(v_ff[hpt_pkg::PIPE_LAT-1]))
      else $error("response appeared without a request in the last stage");

endmodule

[sim/hpt_checker.sv]
`timescale 1ns / 100ps

module hpt_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  hpt_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  hpt_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   input  logic             csr_ready,
   input  logic [7:0]       csr_index,
   input  logic [63:0]      csr_wdata,
   output int               fail_count,
   output int               pending
);

   logic [63:0]      matrix [hpt_pkg::NUM_REGS];
   hpt_pkg::rsp_type expected_points [$];

   function automatic logic signed [31:0] entry_of(int r, int c);
      int          idx;
      logic [63:0] word;
      idx  = r * 4 + c;
      word = matrix[idx >> 1];
      return (idx & 1) ? word[31:0] : word[63:32];
   endfunction

   // floor((a*b) / 2^16), kept exact in 80 bits
   function automatic logic signed [79:0] scaled(logic signed [31:0] a,
                                                 logic signed [31:0] b);
      logic signed [79:0] p;
      p = 80'(a) * 80'(b);
      return p >>> 16;
   endfunction

   function automatic logic signed [79:0] column(hpt_pkg::req_type p, int c);
      return scaled(p.in_x, entry_of(0, c)) + scaled(p.in_y, entry_of(1, c)) +
             scaled(p.in_z, entry_of(2, c)) + 80'(entry_of(3, c));
   endfunction

   function automatic logic [31:0] quotient(logic signed [79:0] n,
                                            logic signed [79:0] w);
      logic [79:0] nm, wm, q;
      logic        neg;
      nm  = n[79] ? -n : n;
      wm  = w[79] ? -w : w;
      neg = n[79] ^ w[79];
      q   = (nm << 16) / wm;
      if (neg) return (q >= 80'h8000_0000) ? hpt_pkg::SAT_NEG : 32'(-q);
      return (q > 80'h7FFF_FFFF) ? hpt_pkg::SAT_POS : q[31:0];
   endfunction

   function automatic hpt_pkg::rsp_type transform_point(hpt_pkg::req_type p);
      hpt_pkg::rsp_type   r;
      logic signed [79:0] w;
      w = column(p, 3);
      r = '0;
      if (w == 0) begin
         r.w_zero = 1'b1;
      end else begin
         r.out_x = quotient(column(p, 0), w);
         r.out_y = quotient(column(p, 1), w);
         r.out_z = quotient(column(p, 2), w);
      end
      return r;
   endfunction

   always @(posedge clock) begin
      hpt_pkg::rsp_type e;
      if (reset) begin
         for (int i = 0; i < hpt_pkg::NUM_REGS; i++) matrix[i] <= hpt_pkg::CFG_RESET[i];
         expected_points.delete();
         fail_count <= 0;
         pending    <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_points.size() == 0) begin
               $error("response with no request outstanding");
               fail_count <= fail_count + 1;
            end else begin
               e = expected_points.pop_front();
               if (e.out_x !== rsp_data.out_x) begin
                  $error("out_x exp %h got %h", e.out_x, rsp_data.out_x);
                  fail_count <= fail_count + 1;
               end
               if (e.out_y !== rsp_data.out_y) begin
                  $error("out_y exp %h got %h", e.out_y, rsp_data.out_y);
                  fail_count <= fail_count + 1;
               end
               if (e.out_z !== rsp_data.out_z) begin
                  $error("out_z exp %h got %h", e.out_z, rsp_data.out_z);
                  fail_count <= fail_count + 1;
               end
               if (e.w_zero !== rsp_data.w_zero) begin
                  $error("w_zero exp %b got %b", e.w_zero, rsp_data.w_zero);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && !req_stall)
            expected_points.push_back(transform_point(req_data));
         if (csr_valid && csr_ready && csr_index < hpt_pkg::NUM_REGS)
            matrix[csr_index[2:0]] <= csr_wdata;
         pending <= expected_points.size();
      end
   end
endmodule

[sim/tb_homogeneous_point_transform.sv]
`timescale 1ns / 100ps

module tb_homogeneous_point_transform;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   hpt_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   hpt_pkg::rsp_type rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [7:0]       csr_index = '0;
   logic [63:0]      csr_wdata = '0;
   int               fail_count;
   int               pending;

   always #1 clock = ~clock;

   homogeneous_point_transform u_dut (.*);

   hpt_checker u_checker (.*);

   // receiver backpressure: mode changes now and then, including no stalls
   int stall_mode = 0;
   always @(posedge clock) begin
      if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 1) == 0);
         default: rsp_stall <= ($urandom_range(0, 9) != 0);
      endcase
   end

   // hold the request until it is taken
   task automatic send_point(hpt_pkg::req_type p);
      req_valid <= 1'b1;
      req_data  <= p;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic idle_cycles(int n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // wait out the pipeline so matrix writes land while nothing is in flight
   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (hpt_pkg::PIPE_LAT + 5) @(posedge clock);
   endtask

   // one write, then csr_valid drops and the port goes quiet
   task automatic write_reg(logic [7:0] idx, logic [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [31:0] rand_coord(int style);
      case (style)
         0: return $urandom;
         1: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
         2: return $urandom_range(0, 32'h0000_0400) - 32'h0000_0200;
         default: begin
            case ($urandom_range(0, 4))
               0: return 32'h7FFF_FFFF;
               1: return 32'h8000_0000;
               2: return 32'h0;
               3: return 32'h0001_0000;
               default: return 32'hFFFF_0000;
            endcase
         end
      endcase
   endfunction

   function automatic logic [63:0] rand_pair(int style);
      return {rand_coord(style), rand_coord(style)};
   endfunction

   // load a whole matrix of one flavor
   task automatic load_matrix(int flavor);
      logic [63:0] bank [hpt_pkg::NUM_REGS];
      for (int i = 0; i < hpt_pkg::NUM_REGS; i++) bank[i] = hpt_pkg::CFG_RESET[i];
      case (flavor)
         0: ;
         1: for (int i = 0; i < hpt_pkg::NUM_REGS; i++) bank[i] = rand_pair(1);
         2: begin
            // affine matrix with a fixed weight: w stays 1.0
            for (int i = 0; i < hpt_pkg::NUM_REGS; i++) bank[i] = rand_pair(1);
            bank[hpt_pkg::REG_M13_M14][31:0] = '0;
            bank[hpt_pkg::REG_M23_M24][31:0] = '0;
            bank[hpt_pkg::REG_M33_M34][31:0] = '0;
            bank[hpt_pkg::REG_M43_M44][31:0] = 32'h0001_0000;
         end
         3: for (int i = 0; i < hpt_pkg::NUM_REGS; i++) bank[i] = rand_pair(0);
         4: for (int i = 0; i < hpt_pkg::NUM_REGS; i++) bank[i] = rand_pair(3);
         default: begin
            // small weight terms so w often rounds to zero
            for (int i = 0; i < hpt_pkg::NUM_REGS; i++) bank[i] = rand_pair(1);
            bank[hpt_pkg::REG_M13_M14][31:0] = rand_coord(2);
            bank[hpt_pkg::REG_M23_M24][31:0] = rand_coord(2);
            bank[hpt_pkg::REG_M33_M34][31:0] = rand_coord(2);
            bank[hpt_pkg::REG_M43_M44][31:0] = $urandom_range(0, 2) - 1;
         end
      endcase
      for (int i = 0; i < hpt_pkg::NUM_REGS; i++) write_reg(i[7:0], bank[i]);
      // out-of-range index must be dropped
      write_reg(8'($urandom_range(hpt_pkg::NUM_REGS, 255)), 64'($urandom));
   endtask

   initial begin
      hpt_pkg::req_type p;
      int               burst;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: identity matrix, field extremes and w zero
      for (int b = 0; b < 32; b++) begin
         p = '0;
         p.in_x = 32'h1 << b;
         p.in_y = ~(32'h1 << b);
         p.in_z = 32'h1 << (31 - b);
         if (b % 3 == 0) send_point(p);
      end
      send_point('{32'h7FFF_FFFF, 32'h8000_0000, 32'h0});
      send_point('{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF});
      send_point('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
      drain();
      // weight is zero for every point
      write_reg(hpt_pkg::REG_M43_M44, 64'h0);
      send_point('{32'h0001_0000, 32'h0002_0000, 32'h0003_0000});
      drain();
      // w tiny: saturation of the quotient in both signs
      write_reg(hpt_pkg::REG_M43_M44, 64'h0000_0000_0000_0001);
      send_point('{32'h0100_0000, 32'hFF00_0000, 32'h0});
      drain();
      write_reg(hpt_pkg::REG_M43_M44, 64'h0000_0000_FFFF_FFFF);
      send_point('{32'h0100_0000, 32'hFF00_0000, 32'h0});
      drain();
      // w of tiny products that round to zero, then to -1
      write_reg(hpt_pkg::REG_M13_M14, 64'h0000_0000_0000_0001);
      write_reg(hpt_pkg::REG_M43_M44, 64'h0);
      send_point('{32'h0000_8000, 32'h0, 32'h0});
      send_point('{32'hFFFF_8000, 32'h0, 32'h0});
      drain();

      // random phases over several matrices, extremes included
      for (int phase = 0; phase < 24; phase++) begin
         load_matrix(phase % 6);
         for (int n = 0; n < 64; ) begin
            burst = $urandom_range(1, 20);
            for (int k = 0; k < burst && n < 64; k++, n++) begin
               p.in_x = rand_coord($urandom_range(0, 3));
               p.in_y = rand_coord($urandom_range(0, 3));
               p.in_z = rand_coord($urandom_range(0, 3));
               send_point(p);
            end
            if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 6));
         end
         drain();
      end

      drain();
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("simulation failed");
      $finish;
   end
endmodule

[homogeneous_point_transform.f]
hdl/hpt_pkg.sv
hdl/hpt_column.sv
hdl/hpt_div_step.sv
hdl/hpt_divider.sv
hdl/homogeneous_point_transform.sv
sim/hpt_checker.sv
sim/tb_homogeneous_point_transform.sv
